// ===== src/dtd_pkg.sv =====
// Shared codes, result kinds and controller/datapath interface structs for the task dispatcher.
package dtd_pkg;

	// Widths of the fixed stream fields
	localparam int IDX_W = 6;
	localparam int REQ_W = 2;
	localparam int STATUS_W = 3;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEP     = 2'd2;
	localparam logic [REQ_W-1:0] REQ_EXECUTE = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LIST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd4;

	// Which result word the datapath loads into the output register
	typedef enum logic [2:0] {
		RES_OK,
		RES_FULL,
		RES_UNKNOWN,
		RES_LIST_FULL,
		RES_TASK,
		RES_NOTHING,
		RES_PEND_MID,
		RES_PEND_LAST
	} res_kind_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic      latch;
		logic      clear;
		logic      add_task;
		logic      rd_cnt_dep;
		logic      add_dep;
		logic      scan_init;
		logic      rd_cnt_scan;
		logic      rd_pre_first;
		logic      rd_pre_next;
		logic      dispatch;
		logic      advance;
		logic      emit;
		res_kind_t kind;
	} dtd_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic table_full;
		logic dep_unknown;
		logic list_full;
		logic tasks_zero;
		logic cur_done;
		logic cnt_zero;
		logic pre_done;
		logic pre_last;
		logic scan_last;
		logic progress;
		logic pend_valid;
		logic out_free;
	} dtd_stat_t;

endpackage

// ===== src/dtd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/dtd_datapath.sv =====
// Datapath: task count, done flags, prerequisite memories, scan counters and output register.
module dtd_datapath import dtd_pkg::*; #(
	parameter int TASK_SLOTS = 64,
	parameter int PREREQ_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dtd_cmd_t            cmd,
	output dtd_stat_t           stat,
	input  logic [IDX_W-1:0]    in_task_index,
	input  logic [IDX_W-1:0]    in_prereq_index,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [IDX_W-1:0]    out_task,
	output logic [STATUS_W-1:0] out_status,
	output logic                out_dispatched,
	output logic                out_last
);

	localparam int IW   = $clog2(TASK_SLOTS);
	localparam int TW   = $clog2(TASK_SLOTS + 1);
	localparam int CNTW = $clog2(PREREQ_SLOTS + 1);
	localparam int LAW  = $clog2(TASK_SLOTS * PREREQ_SLOTS);
	localparam int CW   = (TW > IDX_W) ? TW : IDX_W;

	logic [TW-1:0]          tasks_q;
	logic [TASK_SLOTS-1:0]  done_q;
	logic [IDX_W-1:0]       req_ti_q;
	logic [IDX_W-1:0]       req_pi_q;
	logic [IW-1:0]          scan_i_q;
	logic [CNTW-1:0]        pre_j_q;
	logic                   progress_q;
	logic                   pend_valid_q;
	logic [IW-1:0]          pend_task_q;
	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_task_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic                   out_disp_q;
	logic                   out_last_q;

	logic [IW-1:0]          ti_idx;
	logic [IW-1:0]          new_idx;
	logic [CNTW-1:0]        cnt_rd;
	logic [IW-1:0]          pre_rd;
	logic                   cnt_we;
	logic [IW-1:0]          cnt_waddr;
	logic [CNTW-1:0]        cnt_wdata;
	logic                   cnt_re;
	logic [IW-1:0]          cnt_raddr;
	logic [LAW-1:0]         pre_waddr;
	logic                   pre_re;
	logic [CNTW-1:0]        pre_j_nxt;
	logic [LAW-1:0]         pre_raddr;
	logic                   out_free;

	assign ti_idx  = IW'(req_ti_q);
	assign new_idx = IW'(tasks_q);

	// Latch the fields of an accepted word
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_ti_q <= in_task_index;
			req_pi_q <= in_prereq_index;
		end
	end

	// Task count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tasks_q <= '0;
		end else if (cmd.clear) begin
			tasks_q <= '0;
		end else if (cmd.add_task) begin
			tasks_q <= tasks_q + TW'(1);
		end
	end

	// Done flags: clear all, drop on a new task, set on dispatch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (cmd.clear) begin
			done_q <= '0;
		end else begin
			if (cmd.add_task) begin
				done_q[new_idx] <= 1'b0;
			end
			if (cmd.dispatch) begin
				done_q[scan_i_q] <= 1'b1;
			end
		end
	end

	// Prerequisite count memory: zero on add task, bump on add dependency
	assign cnt_we    = cmd.add_task | cmd.add_dep;
	assign cnt_waddr = cmd.add_task ? new_idx : ti_idx;
	assign cnt_wdata = cmd.add_task ? '0 : cnt_rd + CNTW'(1);
	assign cnt_re    = cmd.rd_cnt_dep | cmd.rd_cnt_scan;
	assign cnt_raddr = cmd.rd_cnt_dep ? ti_idx : scan_i_q;

	dtd_ram #(
		.WIDTH (CNTW),
		.DEPTH (TASK_SLOTS)
	) u_cnt_ram (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (cnt_waddr),
		.wr_data (cnt_wdata),
		.rd_en   (cnt_re),
		.rd_addr (cnt_raddr),
		.rd_data (cnt_rd)
	);

	// Prerequisite list memory, one row of PREREQ_SLOTS entries per task
	assign pre_waddr = LAW'(ti_idx) * LAW'(PREREQ_SLOTS) + LAW'(cnt_rd);
	assign pre_re    = cmd.rd_pre_first | cmd.rd_pre_next;
	assign pre_j_nxt = cmd.rd_pre_first ? '0 : pre_j_q + CNTW'(1);
	assign pre_raddr = LAW'(scan_i_q) * LAW'(PREREQ_SLOTS) + LAW'(pre_j_nxt);

	dtd_ram #(
		.WIDTH (IW),
		.DEPTH (TASK_SLOTS * PREREQ_SLOTS)
	) u_pre_ram (
		.clk     (clk),
		.wr_en   (cmd.add_dep),
		.wr_addr (pre_waddr),
		.wr_data (IW'(req_pi_q)),
		.rd_en   (pre_re),
		.rd_addr (pre_raddr),
		.rd_data (pre_rd)
	);

	// Scan position, prerequisite position, pass progress and pending dispatch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_i_q     <= '0;
			pre_j_q      <= '0;
			progress_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pre_re) begin
				pre_j_q <= pre_j_nxt;
			end
			if (cmd.scan_init) begin
				scan_i_q     <= '0;
				progress_q   <= 1'b0;
				pend_valid_q <= 1'b0;
			end else begin
				if (cmd.advance && stat.scan_last) begin
					progress_q <= 1'b0;
				end else if (cmd.dispatch) begin
					progress_q <= 1'b1;
				end
				if (cmd.advance) begin
					scan_i_q <= stat.scan_last ? '0 : scan_i_q + IW'(1);
				end
				if (cmd.dispatch) begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dispatch) begin
			pend_task_q <= scan_i_q;
		end
	end

	// Output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_task_q   <= '0;
			out_status_q <= ST_OK;
			out_disp_q   <= 1'b0;
			out_last_q   <= 1'b1;
			unique case (cmd.kind)
				RES_OK: begin
				end
				RES_FULL: begin
					out_status_q <= ST_FULL;
				end
				RES_UNKNOWN: begin
					out_status_q <= ST_UNKNOWN;
				end
				RES_LIST_FULL: begin
					out_status_q <= ST_LIST_FULL;
				end
				RES_TASK: begin
					out_task_q <= IDX_W'(tasks_q);
				end
				RES_NOTHING: begin
					out_status_q <= ST_NOTHING;
				end
				RES_PEND_MID: begin
					out_task_q <= IDX_W'(pend_task_q);
					out_disp_q <= 1'b1;
					out_last_q <= 1'b0;
				end
				RES_PEND_LAST: begin
					out_task_q <= IDX_W'(pend_task_q);
					out_disp_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign out_task       = out_task_q;
	assign out_status     = out_status_q;
	assign out_dispatched = out_disp_q;
	assign out_last       = out_last_q;

	// Status towards the controller
	always_comb begin
		stat.table_full  = (tasks_q == TW'(TASK_SLOTS));
		stat.dep_unknown = (CW'(req_ti_q) >= CW'(tasks_q)) || (CW'(req_pi_q) >= CW'(tasks_q));
		stat.list_full   = (cnt_rd == CNTW'(PREREQ_SLOTS));
		stat.tasks_zero  = (tasks_q == '0);
		stat.cur_done    = done_q[scan_i_q];
		stat.cnt_zero    = (cnt_rd == '0);
		stat.pre_done    = done_q[pre_rd];
		stat.pre_last    = ((pre_j_q + CNTW'(1)) == cnt_rd);
		stat.scan_last   = ((TW'(scan_i_q) + TW'(1)) == tasks_q);
		stat.progress    = progress_q;
		stat.pend_valid  = pend_valid_q;
		stat.out_free    = out_free;
	end

endmodule

// ===== src/dtd_ctrl.sv =====
// Controller state machine: request decode, table updates and the execute scan sequence.
module dtd_ctrl import dtd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [REQ_W-1:0] in_req,
	output logic             in_ready,
	input  dtd_stat_t        stat,
	output dtd_cmd_t         cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_ADD   = 4'd2;
	localparam logic [3:0] S_DEPR  = 4'd3;
	localparam logic [3:0] S_DEPW  = 4'd4;
	localparam logic [3:0] S_XINIT = 4'd5;
	localparam logic [3:0] S_XTASK = 4'd6;
	localparam logic [3:0] S_XCNT  = 4'd7;
	localparam logic [3:0] S_XPRE  = 4'd8;
	localparam logic [3:0] S_XDISP = 4'd9;
	localparam logic [3:0] S_XEND  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       end_scan;

	assign in_ready = (state_q == S_IDLE);
	// Leaving the last task of a pass that dispatched nothing ends the scan
	assign end_scan = stat.scan_last && !stat.progress;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = RES_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					unique case (in_req)
						REQ_CLEAR:   state_d = S_CLR;
						REQ_ADD:     state_d = S_ADD;
						REQ_DEP:     state_d = S_DEPR;
						REQ_EXECUTE: state_d = S_XINIT;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				if (stat.out_free) begin
					cmd.clear = 1'b1;
					cmd.emit  = 1'b1;
					cmd.kind  = RES_OK;
					state_d   = S_IDLE;
				end
			end
			S_ADD: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.table_full) begin
						cmd.kind = RES_FULL;
					end else begin
						cmd.add_task = 1'b1;
						cmd.kind     = RES_TASK;
					end
					state_d = S_IDLE;
				end
			end
			S_DEPR: begin
				cmd.rd_cnt_dep = 1'b1;
				state_d        = S_DEPW;
			end
			S_DEPW: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					priority if (stat.dep_unknown) begin
						cmd.kind = RES_UNKNOWN;
					end else if (stat.list_full) begin
						cmd.kind = RES_LIST_FULL;
					end else begin
						cmd.add_dep = 1'b1;
						cmd.kind    = RES_OK;
					end
					state_d = S_IDLE;
				end
			end
			S_XINIT: begin
				cmd.scan_init = 1'b1;
				state_d       = stat.tasks_zero ? S_XEND : S_XTASK;
			end
			S_XTASK: begin
				// Skip a finished task, else fetch its prerequisite count
				if (stat.cur_done) begin
					cmd.advance = 1'b1;
					state_d     = end_scan ? S_XEND : S_XTASK;
				end else begin
					cmd.rd_cnt_scan = 1'b1;
					state_d         = S_XCNT;
				end
			end
			S_XCNT: begin
				if (stat.cnt_zero) begin
					state_d = S_XDISP;
				end else begin
					cmd.rd_pre_first = 1'b1;
					state_d          = S_XPRE;
				end
			end
			S_XPRE: begin
				// Check one prerequisite per cycle
				priority if (!stat.pre_done) begin
					cmd.advance = 1'b1;
					state_d     = end_scan ? S_XEND : S_XTASK;
				end else if (stat.pre_last) begin
					state_d = S_XDISP;
				end else begin
					cmd.rd_pre_next = 1'b1;
				end
			end
			S_XDISP: begin
				// Hand the previous dispatch to the output, hold this one back
				if (!stat.pend_valid || stat.out_free) begin
					cmd.dispatch = 1'b1;
					cmd.advance  = 1'b1;
					cmd.emit     = stat.pend_valid;
					cmd.kind     = RES_PEND_MID;
					state_d      = S_XTASK;
				end
			end
			S_XEND: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = stat.pend_valid ? RES_PEND_LAST : RES_NOTHING;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/dependency_task_dispatcher.sv =====
// Top level of the dependency task dispatcher: controller, datapath and stream ports.
//
//  channel   | direction | tdata                               | tuser / tlast
//  ----------+-----------+-------------------------------------+---------------------------------
//  s_axis    | in        | [5:0] task_index, [11:6] prereq_idx | tuser [1:0] req_type
//  m_axis    | out       | [5:0] result_task                   | tuser [2:0] status, [3] dispatched;
//            |           |                                     | tlast marks the final result
//
// Clear and add task are answered straight after the word is taken; add dependency first reads the count memory.
// Execute: an init step starts the scan, then each pass skips done tasks, reads the prerequisite
// count of any other task and checks its list (one list read a cycle) until it is blocked or
// dispatched; passes repeat until one dispatches nothing, then a last step emits the final result.
// Reset is asynchronous and clears the task count, the done flags and all control state.
// A stalled output holds the result in the output register; the scan waits on it.
module dependency_task_dispatcher import dtd_pkg::*; #(
	parameter int TASK_SLOTS = 64,
	parameter int PREREQ_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] task_index, [11:6] prereq_index, [15:12] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] result_task, [7:6] zero
	output logic [3:0]  m_tuser,   // [2:0] status, [3] dispatched
	output logic        m_tlast
);

	dtd_cmd_t            cmd;
	dtd_stat_t           stat;
	logic [IDX_W-1:0]    res_task;
	logic [STATUS_W-1:0] res_status;
	logic                res_disp;

	dtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_req   (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dtd_datapath #(
		.TASK_SLOTS   (TASK_SLOTS),
		.PREREQ_SLOTS (PREREQ_SLOTS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_task_index   (s_tdata[5:0]),
		.in_prereq_index (s_tdata[11:6]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_task        (res_task),
		.out_status      (res_status),
		.out_dispatched  (res_disp),
		.out_last        (m_tlast)
	);

	// Pack the result word
	assign m_tdata = {2'b00, res_task};
	assign m_tuser = {res_disp, res_status};

endmodule

// ===== bench/tb.sv =====
// Stream testbench for the dependency task dispatcher: directed tables, full table and random graphs.
module tb;
	import dtd_pkg::*;

	localparam int SLOTS = 64;
	localparam int LIST_DEPTH = 8;
	localparam int IDLE_LIMIT = 6000;
	localparam int RANDOM_WORDS = 170;

	typedef struct packed {
		logic [5:0] idx;
		logic [2:0] status;
		logic       disp;
		logic       fin;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	// Mirror of the task table
	bit         tbl_done [SLOTS];
	logic [5:0] tbl_pre [SLOTS][LIST_DEPTH];
	int         tbl_cnt [SLOTS];
	int         tbl_used = 0;

	answer_t answers_due [$];
	int      errors = 0;
	int      words_sent = 0;
	int      quiet_cycles = 0;
	bit      calm = 1'b0;

	dependency_task_dispatcher #(
		.TASK_SLOTS(SLOTS),
		.PREREQ_SLOTS(LIST_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	// Queue one answer word
	function automatic void owe(input logic [5:0] idx, input logic [2:0] status,
		input logic disp, input logic fin);
		answer_t a;
		a.idx = idx;
		a.status = status;
		a.disp = disp;
		a.fin = fin;
		answers_due.push_back(a);
	endfunction

	// Update the mirrored table for one request and queue the words it yields
	function automatic void table_answer(input logic [1:0] rq, input logic [5:0] ti,
		input logic [5:0] pi);
		int  fired [$];
		bit  progress;
		bit  runnable;
		case (rq)
			REQ_CLEAR: begin
				tbl_used = 0;
				for (int i = 0; i < SLOTS; i++) tbl_done[i] = 1'b0;
				owe('0, ST_OK, 1'b0, 1'b1);
			end
			REQ_ADD: begin
				if (tbl_used >= SLOTS) begin
					owe('0, ST_FULL, 1'b0, 1'b1);
				end else begin
					tbl_cnt[tbl_used] = 0;
					tbl_done[tbl_used] = 1'b0;
					owe(tbl_used[5:0], ST_OK, 1'b0, 1'b1);
					tbl_used++;
				end
			end
			REQ_DEP: begin
				if (int'(ti) >= tbl_used || int'(pi) >= tbl_used) begin
					owe('0, ST_UNKNOWN, 1'b0, 1'b1);
				end else if (tbl_cnt[ti] >= LIST_DEPTH) begin
					owe('0, ST_LIST_FULL, 1'b0, 1'b1);
				end else begin
					tbl_pre[ti][tbl_cnt[ti]] = pi;
					tbl_cnt[ti]++;
					owe('0, ST_OK, 1'b0, 1'b1);
				end
			end
			default: begin
				// Repeat passes in index order until one dispatches nothing
				progress = 1'b1;
				while (progress && fired.size() < SLOTS) begin
					progress = 1'b0;
					for (int i = 0; i < tbl_used; i++) begin
						runnable = !tbl_done[i];
						for (int j = 0; j < tbl_cnt[i]; j++)
							if (!tbl_done[tbl_pre[i][j]]) runnable = 1'b0;
						if (runnable) begin
							tbl_done[i] = 1'b1;
							fired.push_back(i);
							progress = 1'b1;
						end
					end
				end
				if (fired.size() == 0) begin
					owe('0, ST_NOTHING, 1'b0, 1'b1);
				end else begin
					for (int k = 0; k < fired.size(); k++)
						owe(fired[k][5:0], ST_OK, 1'b1, k == fired.size() - 1);
				end
			end
		endcase
	endfunction

	// Offer one request word after a random gap and hold it until taken
	task automatic send_req(input logic [1:0] rq, input logic [5:0] ti, input logic [5:0] pi);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq;
		s_tdata <= {4'b0000, pi, ti};
		do @(posedge clk); while (!s_tready);
		table_answer(rq, ti, pi);
		words_sent++;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Take result words with random stalls and compare each with the oldest answer
	initial begin
		int      stall;
		answer_t a;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual tdata %h tuser %h tlast %b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				a = answers_due.pop_front();
				check_field("result_task", a.idx, m_tdata[5:0]);
				check_field("status", a.status, m_tuser[2:0]);
				check_field("dispatched", a.disp, m_tuser[3]);
				check_field("last", a.fin, m_tlast);
			end
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Empty table, unknown index and a task that depends on itself
	task automatic test_empty_table();
		send_req(REQ_EXECUTE, 6'd0, 6'd0);
		send_req(REQ_DEP, 6'd0, 6'd0);
		send_req(REQ_ADD, 6'd0, 6'd0);
		send_req(REQ_DEP, 6'd0, 6'd0);
		send_req(REQ_EXECUTE, 6'd0, 6'd0);
		send_req(REQ_CLEAR, 6'd63, 6'd63);
	endtask

	// Chain over two passes, duplicate entry, repeated execute, then a full list
	task automatic test_dependency_chain();
		repeat (4) send_req(REQ_ADD, 6'd0, 6'd0);
		send_req(REQ_DEP, 6'd2, 6'd1);
		send_req(REQ_DEP, 6'd1, 6'd0);
		send_req(REQ_DEP, 6'd2, 6'd1);
		send_req(REQ_DEP, 6'd0, 6'd3);
		send_req(REQ_DEP, 6'd3, 6'd4);
		send_req(REQ_DEP, 6'd63, 6'd0);
		send_req(REQ_EXECUTE, 6'd0, 6'd0);
		send_req(REQ_EXECUTE, 6'd0, 6'd0);
		send_req(REQ_ADD, 6'd0, 6'd0);
		repeat (LIST_DEPTH + 1) send_req(REQ_DEP, 6'd4, 6'd3);
		send_req(REQ_EXECUTE, 6'd0, 6'd0);
	endtask

	// Fill every slot, overflow it, and dispatch with a cycle left behind
	task automatic test_table_full();
		calm = 1'b1;
		send_req(REQ_CLEAR, 6'd0, 6'd0);
		repeat (SLOTS) send_req(REQ_ADD, 6'd0, 6'd0);
		calm = 1'b0;
		send_req(REQ_ADD, 6'd0, 6'd0);
		send_req(REQ_DEP, 6'd0, 6'd63);
		send_req(REQ_DEP, 6'd62, 6'd63);
		send_req(REQ_DEP, 6'd31, 6'd32);
		send_req(REQ_DEP, 6'd32, 6'd31);
		send_req(REQ_EXECUTE, 6'd0, 6'd0);
		send_req(REQ_EXECUTE, 6'd0, 6'd0);
	endtask

	// Pick an index mostly inside the table, now and then anywhere
	function automatic logic [5:0] pick_index(input int n);
		if (n == 0 || $urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, n - 1));
	endfunction

	// Random graphs: build a table, wire dependencies, execute, sometimes extend
	task automatic test_random_graphs();
		int target;
		int n;
		int hub;
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			calm = ($urandom_range(0, 4) == 0);
			send_req(REQ_CLEAR, 6'($urandom), 6'($urandom));
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
			repeat (n) send_req(REQ_ADD, 6'($urandom), 6'($urandom));
			repeat ($urandom_range(0, 2 * n)) send_req(REQ_DEP, pick_index(n), pick_index(n));
			// Pile onto one task now and then to reach a full list
			if ($urandom_range(0, 9) == 0) begin
				hub = $urandom_range(0, n - 1);
				repeat (LIST_DEPTH + 1) send_req(REQ_DEP, 6'(hub), pick_index(n));
			end
			send_req(REQ_EXECUTE, 6'($urandom), 6'($urandom));
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					send_req(REQ_ADD, 6'($urandom), 6'($urandom));
					n++;
					send_req(REQ_DEP, 6'(n - 1), pick_index(n));
				end
				send_req(REQ_EXECUTE, 6'($urandom), 6'($urandom));
			end
			// Noise words of any kind
			repeat ($urandom_range(0, 3))
				send_req(2'($urandom), 6'($urandom), 6'($urandom));
		end
	endtask

	// Drain outstanding words, allow for stray ones, then report
	task automatic finish_run();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (answers_due.size() != 0);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_dependency_chain();
		test_table_full();
		test_random_graphs();
		finish_run();
	end

endmodule
